// File: hw/rtl/slts_pkg.sv
// Shared types and constants for the sticky largest-target selector.
package slts_pkg;

   localparam int unsigned AreaW   = 17;   // 511 * 255 fits in 17 bits
   localparam int unsigned BlkW    = 75;
   localparam int unsigned TdataW  = 80;
   localparam logic [7:0]  ThrReset = 8'd104;

   // first member in the highest bits, so x lands at bit 0 of the word
   typedef struct packed {
      logic        [7:0]  age;
      logic signed [8:0]  angle;
      logic        [15:0] signature;
      logic        [7:0]  track_id;
      logic        [7:0]  height;
      logic        [8:0]  width;
      logic        [7:0]  y;
      logic        [8:0]  x;
   } blk_type;

   typedef struct packed {
      blk_type              blk;
      logic [AreaW-1:0]     area;   // zero unless the block's y exceeds the row threshold
      logic                 last;
      logic                 empty;
   } entry_type;

endpackage

// File: hw/rtl/slts_front.sv
// Front end: accepts words, holds the row threshold, computes qualified area.
module slts_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [slts_pkg::TdataW-1:0] req_tdata,
   input  logic                       req_tlast,
   input  logic                       req_tuser,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [7:0]                 csr_wdata,
   input  logic                       q_ready_i,
   output logic                       q_push_o,
   output slts_pkg::entry_type        q_entry_o
);

   logic [7:0]                  thr_ff;
   logic [7:0]                  thr_in;
   slts_pkg::blk_type           blk;
   logic [slts_pkg::AreaW-1:0]  area;

   assign csr_ready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      if (csr_valid) begin
         thr_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= slts_pkg::ThrReset;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign blk  = slts_pkg::blk_type'(req_tdata[slts_pkg::BlkW-1:0]);
   assign area = slts_pkg::AreaW'(blk.width) * slts_pkg::AreaW'(blk.height);

   assign req_tready = q_ready_i;
   assign q_push_o   = req_tvalid && q_ready_i;

   always_comb begin
      q_entry_o.blk   = blk;
      q_entry_o.area  = (blk.y > thr_ff) ? area : '0;
      q_entry_o.last  = req_tlast;
      q_entry_o.empty = req_tuser;
   end

endmodule

// File: hw/rtl/slts_queue.sv
// Short queue between the front end and the selection back end.
module slts_queue #(
   parameter int unsigned Depth = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_i,
   input  slts_pkg::entry_type entry_i,
   output logic                ready_o,
   output logic                valid_o,
   output slts_pkg::entry_type entry_o,
   input  logic                pop_i
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   slts_pkg::entry_type  mem_ff [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;

   assign ready_o = (count_ff != CntW'(Depth));
   assign valid_o = (count_ff != '0);
   assign entry_o = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= entry_i;
      end
   end

endmodule

// File: hw/rtl/slts_back.sv
// Back end: tracks lock, sticky match and best candidate; registers the result word.
module slts_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid_i,
   input  slts_pkg::entry_type         head_i,
   output logic                        pop_o,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [slts_pkg::TdataW-1:0] rsp_tdata,
   output logic                        rsp_tuser
);

   logic                        lock_valid_ff, lock_valid_in;
   logic [7:0]                  locked_id_ff, locked_id_in;
   logic                        sticky_hit_ff, sticky_hit_in;
   slts_pkg::blk_type           sticky_blk_ff, sticky_blk_in;
   logic [slts_pkg::AreaW-1:0]  best_area_ff, best_area_in;
   slts_pkg::blk_type           best_blk_ff, best_blk_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   slts_pkg::blk_type           rsp_blk_ff, rsp_blk_in;
   logic                        out_free;
   logic                        ends_frame;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ends_frame = head_i.last || head_i.empty;
   assign pop_o      = head_valid_i && (!ends_frame || out_free);

   always_comb begin
      logic                       s_hit;
      slts_pkg::blk_type          s_blk;
      logic [slts_pkg::AreaW-1:0] b_area;
      slts_pkg::blk_type          b_blk;

      lock_valid_in = lock_valid_ff;
      locked_id_in  = locked_id_ff;
      sticky_hit_in = sticky_hit_ff;
      sticky_blk_in = sticky_blk_ff;
      best_area_in  = best_area_ff;
      best_blk_in   = best_blk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_blk_in    = rsp_blk_ff;

      s_hit  = sticky_hit_ff;
      s_blk  = sticky_blk_ff;
      b_area = best_area_ff;
      b_blk  = best_blk_ff;
      if (lock_valid_ff && !sticky_hit_ff && head_i.blk.track_id == locked_id_ff) begin
         s_hit = 1'b1;
         s_blk = head_i.blk;
      end
      if (head_i.area > best_area_ff) begin
         b_area = head_i.area;
         b_blk  = head_i.blk;
      end

      if (pop_o) begin
         if (head_i.empty) begin
            // empty frame: drop lock and anything gathered so far
            lock_valid_in = 1'b0;
            locked_id_in  = '0;
            sticky_hit_in = 1'b0;
            best_area_in  = '0;
            rsp_valid_in  = 1'b1;
            rsp_found_in  = 1'b0;
            rsp_blk_in    = '0;
         end else if (head_i.last) begin
            sticky_hit_in = 1'b0;
            best_area_in  = '0;
            rsp_valid_in  = 1'b1;
            if (lock_valid_ff && s_hit) begin
               rsp_found_in = 1'b1;
               rsp_blk_in   = s_blk;
            end else if (b_area != '0) begin
               lock_valid_in = 1'b1;
               locked_id_in  = b_blk.track_id;
               rsp_found_in  = 1'b1;
               rsp_blk_in    = b_blk;
            end else begin
               lock_valid_in = 1'b0;
               locked_id_in  = '0;
               rsp_found_in  = 1'b0;
               rsp_blk_in    = '0;
            end
         end else begin
            sticky_hit_in = s_hit;
            sticky_blk_in = s_blk;
            best_area_in  = b_area;
            best_blk_in   = b_blk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_valid_ff <= 1'b0;
         locked_id_ff  <= '0;
         sticky_hit_ff <= 1'b0;
         best_area_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         lock_valid_ff <= lock_valid_in;
         locked_id_ff  <= locked_id_in;
         sticky_hit_ff <= sticky_hit_in;
         best_area_ff  <= best_area_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sticky_blk_ff <= sticky_blk_in;
      best_blk_ff   <= best_blk_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_blk_ff    <= rsp_blk_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {(slts_pkg::TdataW - slts_pkg::BlkW)'(0), rsp_blk_ff};

endmodule

// File: hw/rtl/sticky_largest_target_select.sv
// Top level of the sticky largest-target selector.
// Usage:
//   req_*  : one detected block per word; tlast marks the frame's last word,
//            tuser marks an empty frame (one word, ends the frame on its own).
//   rsp_*  : one word per frame end; tuser = found, tdata = chosen block
//            (all zero when nothing was found).
//   csr_*  : row threshold write, always ready; change it only while idle.
// Throughput: one word per cycle while the queue has room. The front end
// computes the block area and the row-threshold test in the accept cycle and
// pushes into a QueueDepth-entry queue; the back end retires one queued word
// per cycle, except a frame-ending word while the result word is not taken.
// Frame-ending words reach rsp via the queue write, then the result register.
// Reset: threshold 104, no lock held, queue and result register empty.
// Receiver stall: the result register holds; other words still retire, but a
// frame-ending word waits at the queue head, and req_tready drops once the
// queue is full.
module sticky_largest_target_select #(
   parameter int unsigned QueueDepth = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // x[8:0] y[16:9] width[25:17] height[33:26] track_id[41:34]
   // signature[57:42] angle[66:58] age[74:67], zero pad[79:75]
   input  logic [slts_pkg::TdataW-1:0] req_tdata,
   input  logic                        req_tlast,
   // frame_empty
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_x[8:0] out_y[16:9] out_width[25:17] out_height[33:26]
   // out_track_id[41:34] out_signature[57:42] out_angle[66:58] out_age[74:67]
   output logic [slts_pkg::TdataW-1:0] rsp_tdata,
   // found
   output logic                        rsp_tuser,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [7:0]                  csr_wdata
);

   logic                q_ready;
   logic                q_push;
   slts_pkg::entry_type q_entry;
   logic                head_valid;
   slts_pkg::entry_type head;
   logic                pop;

   slts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .q_ready_i  (q_ready),
      .q_push_o   (q_push),
      .q_entry_o  (q_entry)
   );

   slts_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (q_push),
      .entry_i (q_entry),
      .ready_o (q_ready),
      .valid_o (head_valid),
      .entry_o (head),
      .pop_i   (pop)
   );

   slts_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid_i (head_valid),
      .head_i       (head),
      .pop_o        (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule
